// File: hw/rtl/vdm_pkg.sv
// Shared constants and types for the vector distance metric block.
`default_nettype none

package vdm_pkg;

  // Number of coordinates carried by one input word
  localparam int unsigned MAX_DIMS = 3;
  // Default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;
  // Fixed-point format of the result
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DIST_BITS = 42;
  // Width of the metric selector and of the length fields
  localparam int unsigned FUNC_BITS = 2;
  localparam int unsigned LEN_BITS = 2;
  // Widest intermediate value; wider sums wrap at this width
  localparam int unsigned WRAP_BITS = 64;

  // Metric selector codes
  localparam logic [FUNC_BITS-1:0] FUNC_EUCLID    = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_EUCLID_SQ = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_MANHATTAN = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_UNKNOWN   = 2'd3;

  // The value 1.0 in the result format
  localparam logic [DIST_BITS-1:0] ONE_FIXED = DIST_BITS'(1) << FRAC_BITS;

  // Sideband that travels with a word through the square-root pipeline
  typedef struct packed {
    logic                 euclid;
    logic                 mismatch;
    logic [DIST_BITS-1:0] alt;
  } vdm_side_t;

endpackage

`default_nettype wire

// File: hw/rtl/vdm_lane.sv
// One coordinate lane: absolute difference and its square, registered.
`default_nettype none

module vdm_lane #(
  parameter int unsigned COORD_BITS = vdm_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic                    active_i,
  input  wire logic [COORD_BITS-1:0]   a_i,
  input  wire logic [COORD_BITS-1:0]   b_i,
  output logic      [COORD_BITS-1:0]   abs_o,
  output logic      [2*COORD_BITS-1:0] sq_o
);
  import vdm_pkg::*;

  logic [COORD_BITS-1:0]   diff;
  logic [COORD_BITS-1:0]   abs_q;
  logic [2*COORD_BITS-1:0] sq_q;

  // Take the magnitude of the difference; lanes past the length count as zero
  always_comb begin
    if (!active_i) begin
      diff = '0;
    end else if (a_i >= b_i) begin
      diff = a_i - b_i;
    end else begin
      diff = b_i - a_i;
    end
  end

  // Hold difference and square for the merge stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q <= diff;
      sq_q  <= (2*COORD_BITS)'(diff) * (2*COORD_BITS)'(diff);
    end
  end

  assign abs_o = abs_q;
  assign sq_o  = sq_q;

endmodule

`default_nettype wire

// File: hw/rtl/vdm_merge.sv
// Merge stage: sums the lanes and forms the radicand and the non-root result.
`default_nettype none

module vdm_merge #(
  parameter int unsigned COORD_BITS = vdm_pkg::COORD_BITS_DEF,
  parameter int unsigned RAD_W      = 50
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    en_i,
  input  wire logic [vdm_pkg::MAX_DIMS-1:0][COORD_BITS-1:0]   abs_i,
  input  wire logic [vdm_pkg::MAX_DIMS-1:0][2*COORD_BITS-1:0] sq_i,
  input  wire logic [vdm_pkg::FUNC_BITS-1:0]           func_i,
  input  wire logic                                    mismatch_i,
  output logic      [RAD_W-1:0]                        rad_o,
  output vdm_pkg::vdm_side_t                           side_o
);
  import vdm_pkg::*;

  localparam int unsigned SUM_GROW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0;
  localparam int unsigned SQ_W     = 2*COORD_BITS + SUM_GROW;
  localparam int unsigned AB_W     = COORD_BITS + SUM_GROW;

  logic [SQ_W-1:0]      sq_sum;
  logic [AB_W-1:0]      ab_sum;
  logic [WRAP_BITS-1:0] sq_ext;
  logic [WRAP_BITS-1:0] ab_ext;
  logic                 force_one;
  vdm_side_t            side_d;
  logic [RAD_W-1:0]     rad_d;

  logic [RAD_W-1:0]     rad_q;
  vdm_side_t            side_q;

  // Add up the lane results
  always_comb begin
    sq_sum = '0;
    ab_sum = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      sq_sum = sq_sum + SQ_W'(sq_i[i]);
      ab_sum = ab_sum + AB_W'(abs_i[i]);
    end
  end

  // Pick the result for every metric but the root, and form the radicand
  always_comb begin
    sq_ext    = WRAP_BITS'(sq_sum);
    ab_ext    = WRAP_BITS'(ab_sum);
    force_one = (func_i == FUNC_UNKNOWN) || mismatch_i;
    side_d.mismatch = mismatch_i;
    side_d.euclid   = !force_one && (func_i == FUNC_EUCLID);
    if (force_one) begin
      side_d.alt = ONE_FIXED;
    end else if (func_i == FUNC_EUCLID_SQ) begin
      side_d.alt = DIST_BITS'(sq_ext << FRAC_BITS);
    end else begin
      side_d.alt = DIST_BITS'(ab_ext << FRAC_BITS);
    end
    rad_d = RAD_W'(sq_ext << (2*FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign rad_o  = rad_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// File: hw/rtl/vdm_isqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none

module vdm_isqrt #(
  parameter int unsigned RAD_W = 50
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic [RAD_W-1:0]     rad_i,
  input  wire vdm_pkg::vdm_side_t   side_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic      [RAD_W/2-1:0]   root_o,
  output vdm_pkg::vdm_side_t        side_o
);
  import vdm_pkg::*;

  localparam int unsigned RT_W  = RAD_W / 2;
  localparam int unsigned REM_W = RT_W + 2;
  localparam int unsigned CMP_W = REM_W + 2;

  // Stage k reads index k and writes index k+1
  logic      [RT_W:0]                  vld;
  logic      [RT_W:0]                  rdy;
  logic      [RT_W:0][RT_W-1:0]        root;
  vdm_side_t [RT_W:0]                  side;
  logic      [RT_W-1:0][REM_W-1:0]     rem;
  logic      [RT_W-1:0][RAD_W-1:0]     rad;

  assign vld[0]  = valid_i;
  assign root[0] = '0;
  assign side[0] = side_i;
  assign rem[0]  = '0;
  assign rad[0]  = rad_i;
  assign rdy[RT_W] = ready_i;

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic [CMP_W-1:0] r2;
    logic [CMP_W-1:0] trial;
    logic             ge;
    logic             v_q;

    // Bring down the next two radicand bits and try the next root bit
    assign r2    = {rem[k], rad[k][RAD_W-1 -: 2]};
    assign trial = CMP_W'({root[k], 2'b01});
    assign ge    = (r2 >= trial);

    // Advance when this stage is empty or the next one takes its word
    assign rdy[k] = !v_q || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[k]) begin
        v_q <= vld[k];
      end
    end
    assign vld[k+1] = v_q;

    logic [RT_W-1:0] root_q;
    vdm_side_t       side_q;
    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld[k]) begin
        root_q <= {root[k][RT_W-2:0], ge};
        side_q <= side[k];
      end
    end
    assign root[k+1] = root_q;
    assign side[k+1] = side_q;

    // Remainder and remaining radicand bits feed only later stages
    if (k < RT_W - 1) begin : g_carry
      logic [REM_W-1:0] rem_q;
      logic [RAD_W-1:0] rad_q;
      always_ff @(posedge clk_i) begin
        if (rdy[k] && vld[k]) begin
          rem_q <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
          rad_q <= rad[k] << 2;
        end
      end
      assign rem[k+1] = rem_q;
      assign rad[k+1] = rad_q;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld[RT_W];
  assign root_o  = root[RT_W];
  assign side_o  = side[RT_W];

endmodule

`default_nettype wire

// File: hw/rtl/vector_distance_metric.sv
// Top level of the vector distance metric block.
`default_nettype none

// Computes the Euclidean, squared Euclidean or Manhattan distance between two
// points of up to three coordinates, as unsigned fixed point with 8 fraction
// bits; the Euclidean root is truncated toward zero. Lengths that differ, or
// selector 3, give 1.0, and length_mismatch_o flags differing lengths. One
// word is taken every clock cycle while in_stall_o is low; each word passes
// the lane registers, the merge register and then the square-root pipeline,
// which resolves one root bit per stage; the root is half the radicand width
// (25 bits at 16-bit coordinates). Stalls fill bubbles in the pipeline before
// they reach the input side.
module vector_distance_metric #(
  parameter int unsigned COORD_BITS = vdm_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [vdm_pkg::FUNC_BITS-1:0] func_i,
  input  wire logic [vdm_pkg::LEN_BITS-1:0]  len_a_i,
  input  wire logic [vdm_pkg::LEN_BITS-1:0]  len_b_i,
  input  wire logic [COORD_BITS-1:0]         a_coord_0_i,
  input  wire logic [COORD_BITS-1:0]         a_coord_1_i,
  input  wire logic [COORD_BITS-1:0]         a_coord_2_i,
  input  wire logic [COORD_BITS-1:0]         b_coord_0_i,
  input  wire logic [COORD_BITS-1:0]         b_coord_1_i,
  input  wire logic [COORD_BITS-1:0]         b_coord_2_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [vdm_pkg::DIST_BITS-1:0]      dist_value_o,
  output logic                               length_mismatch_o
);
  import vdm_pkg::*;

  localparam int unsigned SUM_GROW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0;
  localparam int unsigned SQ_W     = 2*COORD_BITS + SUM_GROW;
  localparam int unsigned RAD_FULL = SQ_W + 2*FRAC_BITS;
  localparam int unsigned RAD_W    = (RAD_FULL > WRAP_BITS) ? WRAP_BITS : RAD_FULL;
  localparam int unsigned RT_W     = RAD_W / 2;

  logic [MAX_DIMS-1:0][COORD_BITS-1:0]   a_vec;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0]   b_vec;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0]   lane_abs;
  logic [MAX_DIMS-1:0][2*COORD_BITS-1:0] lane_sq;

  logic                 lane_en;
  logic                 lane_rdy;
  logic                 lane_vld_q;
  logic [FUNC_BITS-1:0] func_q;
  logic                 mis_q;

  logic                 mrg_en;
  logic                 mrg_rdy;
  logic                 mrg_vld_q;
  logic [RAD_W-1:0]     mrg_rad;
  vdm_side_t            mrg_side;

  logic                 sqrt_rdy;
  logic                 sqrt_vld;
  logic [RT_W-1:0]      sqrt_root;
  vdm_side_t            sqrt_side;

  assign a_vec = {a_coord_2_i, a_coord_1_i, a_coord_0_i};
  assign b_vec = {b_coord_2_i, b_coord_1_i, b_coord_0_i};

  // Lane stage: one lane per coordinate
  assign lane_rdy   = !lane_vld_q || mrg_rdy;
  assign lane_en    = lane_rdy && in_valid_i;
  assign in_stall_o = !lane_rdy;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
    vdm_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_en),
      .active_i (32'(len_a_i) > i),
      .a_i      (a_vec[i]),
      .b_i      (b_vec[i]),
      .abs_o    (lane_abs[i]),
      .sq_o     (lane_sq[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
    end else if (lane_rdy) begin
      lane_vld_q <= in_valid_i;
    end
  end

  // Hold the selector and the length check next to the lane results
  always_ff @(posedge clk_i) begin
    if (lane_en) begin
      func_q <= func_i;
      mis_q  <= (len_a_i != len_b_i);
    end
  end

  // Merge stage
  assign mrg_rdy = !mrg_vld_q || sqrt_rdy;
  assign mrg_en  = mrg_rdy && lane_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrg_vld_q <= 1'b0;
    end else if (mrg_rdy) begin
      mrg_vld_q <= lane_vld_q;
    end
  end

  vdm_merge #(
    .COORD_BITS (COORD_BITS),
    .RAD_W      (RAD_W)
  ) u_merge (
    .clk_i      (clk_i),
    .en_i       (mrg_en),
    .abs_i      (lane_abs),
    .sq_i       (lane_sq),
    .func_i     (func_q),
    .mismatch_i (mis_q),
    .rad_o      (mrg_rad),
    .side_o     (mrg_side)
  );

  // Square-root pipeline; its last stage is the output register
  vdm_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mrg_vld_q),
    .ready_o (sqrt_rdy),
    .rad_i   (mrg_rad),
    .side_i  (mrg_side),
    .valid_o (sqrt_vld),
    .ready_i (!out_stall_i),
    .root_o  (sqrt_root),
    .side_o  (sqrt_side)
  );

  // Choose the root for the Euclidean metric, the precomputed value otherwise
  assign out_valid_o       = sqrt_vld;
  assign dist_value_o      = sqrt_side.euclid ? DIST_BITS'(sqrt_root) : sqrt_side.alt;
  assign length_mismatch_o = sqrt_side.mismatch;

endmodule

`default_nettype wire
